/* hw/rtl/aes256_block_cipher_defines.svh */
// Assertion macros shared by the checker of the AES-256 block cipher.
// Depends on nothing; included by the checker file only.
`ifndef AES256_BLOCK_CIPHER_DEFINES_SVH
`define AES256_BLOCK_CIPHER_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define AES256_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aes256 check failed");

// Next-cycle implication that is also checked while reset is high.
`define AES256_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("aes256 check failed");

`endif

/* hw/rtl/aes256_pkg.sv */
// Package for the AES-256 block cipher: constants, S-box tables and the
// round transforms. Depends on nothing.
package aes256_pkg;

  localparam int NUM_ROUNDS  = 14;
  localparam int SCHED_WORDS = 60;
  localparam int KEY_WORDS   = 8;

  // Control that travels with each block through the round stages.
  typedef struct packed {
    logic vld;
    logic dec;
  } aes256_ctl_t;

  // Forward S-box, entry i at bits [2047-8i -: 8].
  localparam logic [2047:0] SBOX_FWD = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  // Inverse S-box, same layout.
  localparam logic [2047:0] SBOX_INV = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

  function automatic logic [7:0] sbox_fwd(input logic [7:0] b);
    return SBOX_FWD[2047 - 8 * b -: 8];
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] b);
    return SBOX_INV[2047 - 8 * b -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox_fwd(w[31:24]), sbox_fwd(w[23:16]), sbox_fwd(w[15:8]), sbox_fwd(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Multiplication by the small constants of the column mix.
  function automatic logic [7:0] gm3(input logic [7:0] a);
    return xtime(a) ^ a;
  endfunction

  function automatic logic [7:0] gm9(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ a;
  endfunction

  function automatic logic [7:0] gm11(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
  endfunction

  function automatic logic [7:0] gm13(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
  endfunction

  function automatic logic [7:0] gm14(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
  endfunction

  // Byte n of a state lies at bits [127-8n -: 8]; column c holds bytes 4c..4c+3.
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int c;
    int r;
    t = '0;
    for (c = 0; c < 4; c++) begin
      for (r = 0; r < 4; r++) begin
        if (inv) begin
          t[127 - 8 * (((c + r) & 3) * 4 + r) -: 8] = s[127 - 8 * (c * 4 + r) -: 8];
        end else begin
          t[127 - 8 * (c * 4 + r) -: 8] = s[127 - 8 * (((c + r) & 3) * 4 + r) -: 8];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24];
    a1 = w[23:16];
    a2 = w[15:8];
    a3 = w[7:0];
    return {xtime(a0) ^ gm3(a1) ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ gm3(a2) ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ gm3(a3),
            gm3(a0) ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24];
    a1 = w[23:16];
    a2 = w[15:8];
    a3 = w[7:0];
    return {gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3),
            gm9(a0) ^ gm14(a1) ^ gm11(a2) ^ gm13(a3),
            gm13(a0) ^ gm9(a1) ^ gm14(a2) ^ gm11(a3),
            gm11(a0) ^ gm13(a1) ^ gm9(a2) ^ gm14(a3)};
  endfunction

endpackage

/* hw/rtl/aes256_keyexp.sv */
// AES-256 key schedule: one word a cycle into a 60-word shift line.
// Depends on aes256_pkg.
module aes256_keyexp
  import aes256_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] key,
  output logic         busy,
  output logic [127:0] rkeys [NUM_ROUNDS + 1]
);

  logic [5:0]  cnt;
  logic [7:0]  rc;
  logic [31:0] win [KEY_WORDS];
  logic [31:0] sched [SCHED_WORDS];
  logic [31:0] t;
  logic [31:0] word_next;

  // Next schedule word: the key itself for the first eight, then the recurrence.
  always_comb begin
    t = win[KEY_WORDS - 1];
    if (cnt[2:0] == 3'd0) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
    end else if (cnt[2:0] == 3'd4) begin
      t = sub_word(t);
    end
    if (cnt < 6'(KEY_WORDS)) begin
      word_next = key[255 - 32 * cnt[2:0] -: 32];
    end else begin
      word_next = win[0] ^ t;
    end
  end

  // Sequencer control: runs after reset and after every key write.
  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rc   <= 8'h01;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'(SCHED_WORDS - 1)) begin
        busy <= 1'b0;
      end
      if (cnt >= 6'(KEY_WORDS) && cnt[2:0] == 3'd0) begin
        rc <= xtime(rc);
      end
    end
  end

  // Window and schedule shift lines.
  always_ff @(posedge clk) begin
    if (busy && !start) begin
      for (int i = 0; i < KEY_WORDS - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[KEY_WORDS - 1] <= word_next;
      for (int i = 0; i < SCHED_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[SCHED_WORDS - 1] <= word_next;
    end
  end

  // Round key r is schedule words 4r to 4r+3.
  for (genvar r = 0; r <= NUM_ROUNDS; r++) begin : g_rk
    assign rkeys[r] = {sched[4 * r], sched[4 * r + 1], sched[4 * r + 2], sched[4 * r + 3]};
  end

endmodule

/* hw/rtl/aes256_round.sv */
// One registered AES round stage serving both encryption and decryption.
// Depends on aes256_pkg.
module aes256_round
  import aes256_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         skip_mix,
  input  aes256_ctl_t  ctl_in,
  input  logic [127:0] state_in,
  input  logic [127:0] rk_enc,
  input  logic [127:0] rk_dec,
  output aes256_ctl_t  ctl_out,
  output logic [127:0] state_out
);

  logic [127:0] shifted;
  logic [127:0] subbed;
  logic [127:0] keyed;
  logic [127:0] mixed;
  logic [127:0] result;

  // Row shift and byte substitution; they commute, so both directions share the order.
  always_comb begin
    shifted = shift_rows(state_in, ctl_in.dec);
    for (int n = 0; n < 16; n++) begin
      subbed[127 - 8 * n -: 8] = ctl_in.dec ? sbox_inv(shifted[127 - 8 * n -: 8])
                                            : sbox_fwd(shifted[127 - 8 * n -: 8]);
    end
  end

  // Encryption mixes then adds the key; decryption adds the key then unmixes.
  always_comb begin
    keyed = subbed ^ rk_dec;
    for (int c = 0; c < 4; c++) begin
      mixed[127 - 32 * c -: 32] = ctl_in.dec ? inv_mix_col(keyed[127 - 32 * c -: 32])
                                             : mix_col(subbed[127 - 32 * c -: 32]);
    end
    if (ctl_in.dec) begin
      result = skip_mix ? keyed : mixed;
    end else begin
      result = (skip_mix ? subbed : mixed) ^ rk_enc;
    end
  end

  // Stage register: the valid bit is cleared by reset, the rest simply follows when enabled.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else if (en) begin
      ctl_out   <= ctl_in;
      state_out <= result;
    end
  end

endmodule

/* hw/rtl/aes256_block_cipher.sv */
// AES-256 block cipher, fully unrolled: an initial key stage and 14 round stages.
// One block per cycle is taken unless stalled or busy rebuilding the key schedule.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset is synchronous; after reset and after each key write the 60-word key
// schedule is rebuilt one word a cycle, so no block is taken until it is complete.
module aes256_block_cipher
  import aes256_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // block_high [63:0], block_low [127:64]
  input  logic         s_tuser,   // opcode [0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // result_high [63:0], result_low [127:64]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  logic [63:0]  key_reg [4];
  logic         cfg_wr;
  logic         busy;
  logic         adv;
  logic [127:0] rkeys [NUM_ROUNDS + 1];
  aes256_ctl_t  ctl [NUM_ROUNDS + 1];
  logic [127:0] st  [NUM_ROUNDS + 1];
  logic [127:0] blk_in;

  // Configuration port: key registers at byte addresses 0, 8, 16 and 24.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = key_reg[paddr[4:3]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        key_reg[i] <= '0;
      end
    end else if (cfg_wr) begin
      key_reg[paddr[4:3]] <= pwdata;
    end
  end

  aes256_keyexp u_keyexp (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_wr),
    .key   ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
    .busy  (busy),
    .rkeys (rkeys)
  );

  // The pipeline moves as one whenever the last stage is empty or being taken.
  assign adv      = !ctl[NUM_ROUNDS].vld || m_tready;
  assign s_tready = adv && !busy;
  assign blk_in   = {s_tdata[63:0], s_tdata[127:64]};

  // Initial key addition.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].vld <= 1'b0;
    end else if (adv) begin
      ctl[0].vld <= s_tvalid && s_tready;
      ctl[0].dec <= s_tuser;
      st[0]      <= blk_in ^ (s_tuser ? rkeys[NUM_ROUNDS] : rkeys[0]);
    end
  end

  // Round stages; the last one leaves out the column mix.
  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    aes256_round u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .skip_mix  (r == NUM_ROUNDS),
      .ctl_in    (ctl[r - 1]),
      .state_in  (st[r - 1]),
      .rk_enc    (rkeys[r]),
      .rk_dec    (rkeys[NUM_ROUNDS - r]),
      .ctl_out   (ctl[r]),
      .state_out (st[r])
    );
  end

  assign m_tvalid = ctl[NUM_ROUNDS].vld;
  assign m_tdata  = {st[NUM_ROUNDS][63:0], st[NUM_ROUNDS][127:64]};

endmodule

/* hw/rtl/aes256_checker.sv */
// Port-level checker for the AES-256 block cipher, bound to the top level.
// Depends on aes256_block_cipher_defines.svh.
`include "aes256_block_cipher_defines.svh"

module aes256_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic         psel,
  input logic         penable,
  input logic         pwrite
);

  // A stalled result stays put.
  `AES256_ASSERT_IMP(a_hold, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata)))
  // A key write stops input while the schedule is rebuilt.
  `AES256_ASSERT_IMP(a_rekey, psel && penable && pwrite, ##1 !s_tready)
  // Reset empties the pipeline and starts the schedule.
  `AES256_ASSERT_NEXT(a_reset, rst, !m_tvalid && !s_tready)

endmodule

bind aes256_block_cipher aes256_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite)
);

/* tb/aes256_block_cipher_tb.sv */
// Self-checking testbench for the AES-256 block cipher: streaming blocks in and out,
// with key writes over the register port. Depends on aes256_pkg and the cipher RTL.
module aes256_block_cipher_tb;
  import aes256_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 30;
  localparam logic OP_ENCRYPT   = 1'b0;
  localparam logic OP_DECRYPT   = 1'b1;
  localparam logic [4:0] ADDR_KEY0 = 5'd0;
  localparam logic [4:0] ADDR_KEY1 = 5'd8;
  localparam logic [4:0] ADDR_KEY2 = 5'd16;
  localparam logic [4:0] ADDR_KEY3 = 5'd24;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_block_t;

  typedef struct {
    logic          op;
    logic [63:0]   hi;
    logic [63:0]   lo;
    bit            typed;
    cipher_block_t want;
  } vector_row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;   // block_high [63:0], block_low [127:64]
  logic         s_tuser;   // opcode [0]
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;   // result_high [63:0], result_low [127:64]
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [63:0]  pwdata;
  logic [63:0]  prdata;
  logic         pready;

  aes256_block_cipher uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [7:0]    sub_tab [256];
  logic [7:0]    unsub_tab [256];
  logic [31:0]   sched [60];
  logic [63:0]   key_reg [4];
  cipher_block_t pending_results [$];
  int            errors;
  int            blocks_sent;
  int            blocks_seen;
  int            quiet_cycles;
  bit            steady;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Field arithmetic in GF(2^8) with the AES polynomial.
  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) acc ^= a;
      a = gf_double(a);
    end
    return acc;
  endfunction

  // Builds both substitution tables from the multiplicative inverse and affine map.
  function automatic void build_sub_tables();
    logic [7:0] inv;
    logic [7:0] y;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int n = 0; n < 254; n++) inv = gf_product(inv, x[7:0]);
      if (x == 0) inv = 8'h00;
      y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tab[x] = y;
      unsub_tab[y] = x[7:0];
    end
  endfunction

  // Rebuilds the 60-word schedule from the four key registers.
  function automatic void expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++)
      sched[i] = (i % 2 == 0) ? key_reg[i / 2][63:32] : key_reg[i / 2][31:0];
    for (int i = 8; i < 60; i++) begin
      t = sched[i - 1];
      if (i % 8 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sub_tab[t[31:24]], sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = gf_double(rc);
      end else if (i % 8 == 4) begin
        t = {sub_tab[t[31:24]], sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]]};
      end
      sched[i] = sched[i - 8] ^ t;
    end
  endfunction

  // State byte n sits at bits [127-8n -: 8]; column c holds bytes 4c to 4c+3.
  function automatic logic [127:0] mix_round_key(input logic [127:0] v, input int rnd);
    for (int c = 0; c < 4; c++) v[127 - 32 * c -: 32] ^= sched[rnd * 4 + c];
    return v;
  endfunction

  function automatic logic [127:0] substitute(input logic [127:0] v, input logic inv);
    for (int n = 0; n < 16; n++)
      v[127 - 8 * n -: 8] = inv ? unsub_tab[v[127 - 8 * n -: 8]] : sub_tab[v[127 - 8 * n -: 8]];
    return v;
  endfunction

  function automatic logic [127:0] rotate_rows(input logic [127:0] v, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) t[127 - 8 * (((c + r) & 3) * 4 + r) -: 8] = v[127 - 8 * (c * 4 + r) -: 8];
        else t[127 - 8 * (c * 4 + r) -: 8] = v[127 - 8 * (((c + r) & 3) * 4 + r) -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [7:0] column_coef(input int idx, input logic inv);
    case (idx)
      0: return inv ? 8'd14 : 8'd2;
      1: return inv ? 8'd11 : 8'd3;
      2: return inv ? 8'd13 : 8'd1;
      default: return inv ? 8'd9 : 8'd1;
    endcase
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] v, input logic inv);
    logic [127:0] t;
    logic [7:0]   acc;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++)
          acc ^= gf_product(column_coef((k - r) & 3, inv), v[127 - 8 * (c * 4 + k) -: 8]);
        t[127 - 8 * (c * 4 + r) -: 8] = acc;
      end
    end
    return t;
  endfunction

  // Full 14-round encryption or decryption of one block under the current schedule.
  function automatic cipher_block_t aes256_transform(input logic op, input logic [63:0] hi,
                                                     input logic [63:0] lo);
    logic [127:0] v;
    v = {hi, lo};
    if (op == OP_ENCRYPT) begin
      v = mix_round_key(v, 0);
      for (int rnd = 1; rnd < 14; rnd++)
        v = mix_round_key(mix_columns(rotate_rows(substitute(v, 1'b0), 1'b0), 1'b0), rnd);
      v = mix_round_key(rotate_rows(substitute(v, 1'b0), 1'b0), 14);
    end else begin
      v = mix_round_key(v, 14);
      for (int rnd = 13; rnd > 0; rnd--)
        v = mix_columns(mix_round_key(substitute(rotate_rows(v, 1'b1), 1'b1), rnd), 1'b1);
      v = mix_round_key(substitute(rotate_rows(v, 1'b1), 1'b1), 0);
    end
    return v;
  endfunction

  // One register write: a setup phase, then an access phase.
  task automatic write_key(input logic [4:0] addr, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    key_reg[addr[4:3]] = value;
    expand_schedule();
  endtask

  // Offers one block after a random gap and waits for its transfer.
  task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo,
                            input bit typed, input cipher_block_t want);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {lo, hi};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(typed ? want : aes256_transform(op, hi, lo));
    blocks_sent++;
  endtask

  // Lets the pipeline empty before the key changes.
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random phase: mostly random blocks, some round trips and extremes.
  task automatic random_phase(input int count);
    logic [63:0]   hi;
    logic [63:0]   lo;
    logic          op;
    cipher_block_t ct;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      op = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: begin hi = '1; lo = '1; end
        1: begin hi = '0; lo = '0; end
        2: begin
          // Encrypt then decrypt the ciphertext to close the loop.
          hi = {$urandom, $urandom};
          lo = {$urandom, $urandom};
          ct = aes256_transform(OP_ENCRYPT, hi, lo);
          send_block(OP_ENCRYPT, hi, lo, 1'b0, '0);
          op = OP_DECRYPT;
          hi = ct.hi;
          lo = ct.lo;
        end
        default: begin
          hi = {$urandom, $urandom};
          lo = {$urandom, $urandom};
        end
      endcase
      send_block(op, hi, lo, 1'b0, '0);
    end
    steady = 1'b0;
  endtask

  // Receiver: a random stall after each result taken, none while steady is set.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    m_tready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(m_tvalid && m_tready));
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    cipher_block_t want;
    cipher_block_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[63:0], m_tdata[127:64]};
        blocks_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h_%h", $time, got.hi, got.lo);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.hi !== want.hi) begin
            $display("%0t: result_high mismatch, expected %h, actual %h", $time, want.hi, got.hi);
            errors++;
          end
          if (got.lo !== want.lo) begin
            $display("%0t: result_low mismatch, expected %h, actual %h", $time, want.lo, got.lo);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed blocks under the zero key, then key phases.
  initial begin
    vector_row_t rows [$];
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    errors = 0;
    blocks_sent = 0;
    blocks_seen = 0;
    quiet_cycles = 0;
    steady = 1'b0;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    build_sub_tables();
    expand_schedule();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Zero key after reset: known answers, then extremes and single-bit patterns.
    rows.push_back('{OP_ENCRYPT, 64'h0, 64'h0, 1'b1,
                     {64'hdc95c078a2408989, 64'had48a21492842087}});
    rows.push_back('{OP_DECRYPT, 64'hdc95c078a2408989, 64'had48a21492842087, 1'b1,
                     {64'h0, 64'h0}});
    rows.push_back('{OP_DECRYPT, 64'h0, 64'h0, 1'b0, '0});
    rows.push_back('{OP_ENCRYPT, '1, '1, 1'b0, '0});
    rows.push_back('{OP_DECRYPT, '1, '1, 1'b0, '0});
    rows.push_back('{OP_ENCRYPT, 64'h8000000000000000, 64'h0, 1'b0, '0});
    rows.push_back('{OP_ENCRYPT, 64'h0, 64'h0000000000000001, 1'b0, '0});
    rows.push_back('{OP_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, '0});
    rows.push_back('{OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, '0});
    foreach (rows[i]) send_block(rows[i].op, rows[i].hi, rows[i].lo, rows[i].typed, rows[i].want);
    drain_pipeline();

    // Standard key 00..1f with its published vector.
    write_key(ADDR_KEY0, 64'h0001020304050607);
    write_key(ADDR_KEY1, 64'h08090a0b0c0d0e0f);
    write_key(ADDR_KEY2, 64'h1011121314151617);
    write_key(ADDR_KEY3, 64'h18191a1b1c1d1e1f);
    send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
               {64'h8ea2b7ca516745bf, 64'heafc49904b496089});
    send_block(OP_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1,
               {64'h0011223344556677, 64'h8899aabbccddeeff});
    random_phase(150);
    drain_pipeline();

    // All-ones key.
    write_key(ADDR_KEY0, '1);
    write_key(ADDR_KEY1, '1);
    write_key(ADDR_KEY2, '1);
    write_key(ADDR_KEY3, '1);
    random_phase(150);

    // Random keys, with partial updates between phases.
    for (int p = 0; p < 3; p++) begin
      drain_pipeline();
      write_key(ADDR_KEY0, {$urandom, $urandom});
      write_key(ADDR_KEY2, {$urandom, $urandom});
      if (p != 1) write_key(ADDR_KEY1, {$urandom, $urandom});
      if (p != 2) write_key(ADDR_KEY3, {$urandom, $urandom});
      random_phase(150);
    end

    // Back to the zero key to close.
    drain_pipeline();
    write_key(ADDR_KEY0, '0);
    write_key(ADDR_KEY1, '0);
    write_key(ADDR_KEY2, '0);
    write_key(ADDR_KEY3, '0);
    random_phase(40);

    drain_pipeline();
    $display("Sent %0d blocks and checked %0d results under seven key settings,", blocks_sent,
             blocks_seen);
    $display("covering encryption, decryption, round trips and random stalls; %0d errors.",
             errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
